// ===== rtl/utf8d_pkg.sv =====
// shared types, constants and helpers of the utf-8 escape decoder
package utf8d_pkg;

   localparam int MIN_HEX_DIGITS_DEFAULT = 4;
   localparam int QUEUE_DEPTH_DEFAULT    = 4;

   localparam int CP_WIDTH   = 21;
   localparam int NDIG_WIDTH = 3;

   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_LOWER_U   = 8'h75;
   localparam logic [7:0] CHAR_ERROR     = 8'h00;

   typedef enum logic [1:0] {
      CMD_PASS,
      CMD_ESC,
      CMD_ERR
   } cmd_kind_type;

   // one unit of work handed from the classifier to the expander
   typedef struct packed {
      cmd_kind_type          kind;
      logic [CP_WIDTH-1:0]   data;
      logic [NDIG_WIDTH-1:0] ndig;
      logic                  eos;
   } cmd_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] ch;
      if (nib < 4'd10) begin
         ch = 8'h30 + {4'd0, nib};
      end else begin
         ch = 8'h37 + {4'd0, nib};
      end
      return ch;
   endfunction

endpackage

// ===== rtl/utf8d_front.sv =====
// front end: accepts bytes, tracks the multibyte sequence and issues commands
module utf8d_front
   import utf8d_pkg::*;
#(
   parameter int MIN_HEX_DIGITS = MIN_HEX_DIGITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] in_byte,
   input  logic       end_of_string,
   output logic       push,
   output cmd_type    cmd
);

   localparam int MINW_CLAMP = (MIN_HEX_DIGITS < 1) ? 1 :
                               (MIN_HEX_DIGITS > 6) ? 6 : MIN_HEX_DIGITS;
   localparam logic [NDIG_WIDTH-1:0] MINW = NDIG_WIDTH'(MINW_CLAMP);

   logic [1:0]          br_ff, br_in;
   logic [CP_WIDTH-1:0] acc_ff, acc_in;
   logic                halted_ff, halted_in;

   logic [CP_WIDTH-1:0]   cont_acc;
   logic [23:0]           cp_pad;
   logic [NDIG_WIDTH-1:0] need;
   logic [NDIG_WIDTH-1:0] ndig;
   logic                  take_err;

   assign cont_acc = {acc_ff[CP_WIDTH-7:0], in_byte[5:0]};
   assign cp_pad   = {3'd0, cont_acc};

   // significant hex digits of the finished code point, raised to the minimum digit count
   always_comb begin
      need = NDIG_WIDTH'(1);
      for (int i = 1; i < 6; i++) begin
         if (cp_pad[4*i +: 4] != 4'd0) begin
            need = NDIG_WIDTH'(i + 1);
         end
      end
      ndig = (need > MINW) ? need : MINW;
   end

   always_comb begin
      br_in     = br_ff;
      acc_in    = acc_ff;
      halted_in = halted_ff;
      push      = 1'b0;
      take_err  = 1'b0;
      cmd.kind  = CMD_PASS;
      cmd.data  = {{(CP_WIDTH-8){1'b0}}, in_byte};
      cmd.ndig  = ndig;
      cmd.eos   = end_of_string;
      if (accept) begin
         if (halted_ff) begin
            if (end_of_string) begin
               halted_in = 1'b0;
               br_in     = 2'd0;
               acc_in    = '0;
            end
         end else if (br_ff != 2'd0) begin
            if (in_byte[7:6] != 2'b10) begin
               take_err = 1'b1;
            end else if (br_ff == 2'd1) begin
               push     = 1'b1;
               cmd.kind = CMD_ESC;
               cmd.data = cont_acc;
               br_in    = 2'd0;
               acc_in   = '0;
            end else if (end_of_string) begin
               take_err = 1'b1;
            end else begin
               acc_in = cont_acc;
               br_in  = br_ff - 2'd1;
            end
         end else if (!in_byte[7]) begin
            push = 1'b1;
         end else begin
            priority if (in_byte[7:5] == 3'b110) begin
               acc_in = {{(CP_WIDTH-5){1'b0}}, in_byte[4:0]};
               br_in  = 2'd1;
            end else if (in_byte[7:4] == 4'b1110) begin
               acc_in = {{(CP_WIDTH-4){1'b0}}, in_byte[3:0]};
               br_in  = 2'd2;
            end else if (in_byte[7:3] == 5'b11110) begin
               acc_in = {{(CP_WIDTH-3){1'b0}}, in_byte[2:0]};
               br_in  = 2'd3;
            end else begin
               take_err = 1'b1;
            end
            // a lead byte that ends the string is a truncated sequence
            if (end_of_string) begin
               take_err = 1'b1;
            end
         end
         if (take_err) begin
            push      = 1'b1;
            cmd.kind  = CMD_ERR;
            cmd.data  = '0;
            br_in     = 2'd0;
            acc_in    = '0;
            halted_in = !end_of_string;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         br_ff     <= 2'd0;
         acc_ff    <= '0;
         halted_ff <= 1'b0;
      end else begin
         br_ff     <= br_in;
         acc_ff    <= acc_in;
         halted_ff <= halted_in;
      end
   end

endmodule

// ===== rtl/utf8d_queue.sv =====
// short command queue between the front end and the expander
module utf8d_queue
   import utf8d_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output cmd_type head,
   output logic    empty,
   output logic    full
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

   cmd_type         slot_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == DEPTH_C);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop))
      else $error("command pushed into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("command popped from an empty queue");

endmodule

// ===== rtl/utf8d_back.sv =====
// expander: turns queued commands into output characters, one beat per cycle while the output is not stalled
module utf8d_back
   import utf8d_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    head,
   input  logic       empty,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic       rsp_is_error,
   output logic       rsp_run_last,
   output logic       rsp_string_done
);

   logic [2:0] step_ff, step_in;
   logic       valid_ff, valid_in;
   logic [7:0] char_ff, char_in;
   logic       err_ff, err_in;
   logic       last_ff, last_in;
   logic       done_ff, done_in;

   logic        slot_free;
   logic        emit;
   logic        is_last;
   logic [3:0]  digit_pos;
   logic [23:0] cp_pad;
   logic [3:0]  nib;

   assign slot_free = !valid_ff || !rsp_stall;
   assign emit      = slot_free && !empty;
   assign cp_pad    = {3'd0, head.data};
   // digit position counted from the least significant nibble
   assign digit_pos = {1'b0, head.ndig} + 4'd1 - {1'b0, step_ff};
   assign is_last   = (head.kind != CMD_ESC) ||
                      ({1'b0, step_ff} == {1'b0, head.ndig} + 4'd1);
   assign pop       = emit && is_last;

   always_comb begin
      unique case (digit_pos[2:0])
         3'd0:    nib = cp_pad[3:0];
         3'd1:    nib = cp_pad[7:4];
         3'd2:    nib = cp_pad[11:8];
         3'd3:    nib = cp_pad[15:12];
         3'd4:    nib = cp_pad[19:16];
         3'd5:    nib = cp_pad[23:20];
         default: nib = 4'd0;
      endcase
   end

   always_comb begin
      step_in  = step_ff;
      valid_in = valid_ff;
      char_in  = char_ff;
      err_in   = err_ff;
      last_in  = last_ff;
      done_in  = done_ff;
      if (slot_free) begin
         valid_in = emit;
      end
      if (emit) begin
         step_in = is_last ? 3'd0 : step_ff + 3'd1;
         err_in  = 1'b0;
         last_in = is_last;
         done_in = is_last && head.eos;
         unique case (head.kind)
            CMD_PASS: char_in = head.data[7:0];
            CMD_ESC: begin
               if (step_ff == 3'd0) begin
                  char_in = CHAR_BACKSLASH;
               end else if (step_ff == 3'd1) begin
                  char_in = CHAR_LOWER_U;
               end else begin
                  char_in = hex_char(nib);
               end
            end
            CMD_ERR: begin
               char_in = CHAR_ERROR;
               err_in  = 1'b1;
            end
            default: char_in = CHAR_ERROR;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
      char_ff <= char_in;
      err_ff  <= err_in;
      last_ff <= last_in;
      done_ff <= done_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_char    = char_ff;
   assign rsp_is_error    = err_ff;
   assign rsp_run_last    = last_ff;
   assign rsp_string_done = done_ff;

   a_error_single_beat: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && err_ff) |-> last_ff)
      else $error("error beat not marked as last of its byte");

   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      !empty |-> ({1'b0, step_ff} <= {1'b0, head.ndig} + 4'd1))
      else $error("expander step ran past the escape text");

endmodule

// ===== rtl/utf8_to_unicode_escape_decoder_core.sv =====
// utf-8 to \u escape decoder; the expander sends one beat per cycle while the output
// is not stalled, taking each command from the queue register into its output register
// an ascii byte gives one beat, a multibyte sequence gives a backslash, a u and its
// hex digits on its final byte, and its lead and middle bytes give no beat
// a 4-entry command queue lets bytes keep coming while the expander is busy
// synchronous reset clears the decode state, the queue and the output valid
module utf8_to_unicode_escape_decoder_core
   import utf8d_pkg::*;
#(
   parameter int MIN_HEX_DIGITS = MIN_HEX_DIGITS_DEFAULT,
   parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_string,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic       rsp_is_error,
   output logic       rsp_run_last,
   output logic       rsp_string_done
);

   logic    accept;
   logic    push;
   cmd_type push_cmd;
   logic    pop;
   cmd_type head;
   logic    empty;
   logic    full;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   utf8d_front #(
      .MIN_HEX_DIGITS(MIN_HEX_DIGITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .in_byte      (req_in_byte),
      .end_of_string(req_end_of_string),
      .push         (push),
      .cmd          (push_cmd)
   );

   utf8d_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_cmd(push_cmd),
      .pop     (pop),
      .head    (head),
      .empty   (empty),
      .full    (full)
   );

   utf8d_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .empty          (empty),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_char   (rsp_out_char),
      .rsp_is_error   (rsp_is_error),
      .rsp_run_last   (rsp_run_last),
      .rsp_string_done(rsp_string_done)
   );

endmodule
